@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("property violated");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ hdl/ffara_pkg.sv @@
// ----------------------------------------------------------------------------
// ffara_pkg
// shared types and constants of the first-fit atlas rectangle allocator
// ----------------------------------------------------------------------------
package ffara_pkg;

  localparam int unsigned ItemW     = 13;
  localparam int unsigned CfgW      = 13;
  localparam int unsigned PadW      = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned OutIdxW   = 3;
  localparam int unsigned OutCoordW = 13;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 56;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEF_W   = 2'd0,
    CFG_DEF_H   = 2'd1,
    CFG_BORDER  = 2'd2,
    CFG_SPACING = 2'd3
  } cfg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ATLAS = 7'b0000010,
    ST_ROW   = 7'b0000100,
    ST_COL   = 7'b0001000,
    ST_RD    = 7'b0010000,
    ST_CMP   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load_item;
    logic first_atlas;
    logic atlas_init;
    logic next_atlas;
    logic open_new;
    logic row_init;
    logic next_row;
    logic col_init;
    logic next_col;
    logic next_region;
    logic place;
    logic set_fail;
  } cmd_t;

  typedef struct packed {
    logic atlases_done;
    logic atlas_full;
    logic can_open;
    logic row_ok;
    logic col_ok;
    logic regions_done;
    logic overlap;
  } stat_t;

endpackage

@@ hdl/ffara_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffara_ctrl
// search sequencer: walks atlases, rows, columns and stored regions
// ----------------------------------------------------------------------------
module ffara_ctrl import ffara_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item   = 1'b1;
          cmd_o.first_atlas = 1'b1;
          state_d           = ST_ATLAS;
        end
      end
      ST_ATLAS: begin
        if (stat_i.atlases_done) begin
          if (stat_i.can_open) begin
            cmd_o.open_new = 1'b1;
            state_d        = ST_ROW;
          end else begin
            cmd_o.set_fail = 1'b1;
            state_d        = ST_OUT;
          end
        end else if (stat_i.atlas_full) begin
          cmd_o.next_atlas = 1'b1;
        end else begin
          cmd_o.atlas_init = 1'b1;
          state_d          = ST_ROW;
        end
      end
      ST_ROW: begin
        if (stat_i.row_ok) begin
          cmd_o.row_init = 1'b1;
          state_d        = ST_COL;
        end else begin
          cmd_o.next_atlas = 1'b1;
          state_d          = ST_ATLAS;
        end
      end
      ST_COL: begin
        if (stat_i.col_ok) begin
          cmd_o.col_init = 1'b1;
          state_d        = ST_RD;
        end else begin
          cmd_o.next_row = 1'b1;
          state_d        = ST_ROW;
        end
      end
      ST_RD: begin
        // region read is issued here, compared in the next cycle
        if (stat_i.regions_done) begin
          cmd_o.place = 1'b1;
          state_d     = ST_OUT;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (stat_i.overlap) begin
          cmd_o.next_col = 1'b1;
          state_d        = ST_COL;
        end else begin
          cmd_o.next_region = 1'b1;
          state_d           = ST_RD;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

endmodule

@@ hdl/ffara_dp.sv @@
// ----------------------------------------------------------------------------
// ffara_dp
// allocator datapath: config, atlas table, region memory, slot compare
// ----------------------------------------------------------------------------
module ffara_dp import ffara_pkg::*; #(
  parameter int unsigned MAX_ATLASES = 8,
  parameter int unsigned MAX_REGIONS = 64,
  parameter int unsigned MAX_DIM     = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  input  logic [ItemW-1:0]     item_width_i,
  input  logic [ItemW-1:0]     item_height_i,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  output logic                 status_o,
  output logic [OutIdxW-1:0]   atlas_index_o,
  output logic [OutCoordW-1:0] pos_x_o,
  output logic [OutCoordW-1:0] pos_y_o,
  output logic [OutCoordW-1:0] atlas_w_o,
  output logic [OutCoordW-1:0] atlas_h_o
);

  localparam int unsigned ACW   = $clog2(MAX_ATLASES + 1);
  localparam int unsigned AIW   = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1;
  localparam int unsigned UCW   = $clog2(MAX_REGIONS + 1);
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned RW    = $clog2(MAX_DIM + 256);
  localparam int unsigned BASEW = (DW > ItemW) ? DW : ItemW;
  localparam int unsigned SW    = BASEW + 3;
  localparam int unsigned RECW  = 2 * DW + 2 * RW;
  localparam int unsigned DEPTH = MAX_ATLASES * MAX_REGIONS;
  localparam int unsigned MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [CfgW-1:0] def_w_q, def_h_q;
  logic [PadW-1:0] border_q, spacing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_w_q   <= CfgW'(1024);
      def_h_q   <= CfgW'(1024);
      border_q  <= '0;
      spacing_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEF_W:   def_w_q   <= cfg_data_i;
        CFG_DEF_H:   def_h_q   <= cfg_data_i;
        CFG_BORDER:  border_q  <= cfg_data_i[PadW-1:0];
        CFG_SPACING: spacing_q <= cfg_data_i[PadW-1:0];
        default:     def_w_q   <= def_w_q;
      endcase
    end
  end

  // search state
  logic [ACW-1:0]   open_q, cur_a_q;
  logic [UCW-1:0]   used_q [MAX_ATLASES];
  logic [UCW-1:0]   i_q;
  logic [DW-1:0]    dim_w_q [MAX_ATLASES];
  logic [DW-1:0]    dim_h_q [MAX_ATLASES];
  logic [ItemW-1:0] item_w_q, item_h_q;
  logic [PadW-1:0]  ub_q, vb_q;
  logic [SW-1:0]    sw_q, sh_q, u_q, v_q;
  logic [RECW-1:0]  mem_q [DEPTH];
  logic [RECW-1:0]  rd_q;

  logic [AIW-1:0] a_idx, o_idx;
  logic [UCW-1:0] used_cur;
  logic [SW-1:0]  aw, ah;
  logic [MAW-1:0] addr;

  assign a_idx    = cur_a_q[AIW-1:0];
  assign o_idx    = open_q[AIW-1:0];
  assign used_cur = used_q[a_idx];
  assign aw       = SW'(dim_w_q[a_idx]);
  assign ah       = SW'(dim_h_q[a_idx]);
  assign addr     = MAW'(a_idx) * MAW'(MAX_REGIONS) + MAW'(i_q);

  // stored region fields, from the lowest bit up: x, y, w, h
  logic [SW-1:0] rx, ry, rw, rh;
  assign rx = SW'(rd_q[DW-1:0]);
  assign ry = SW'(rd_q[2*DW-1:DW]);
  assign rw = SW'(rd_q[2*DW+RW-1:2*DW]);
  assign rh = SW'(rd_q[RECW-1:2*DW+RW]);

  logic ov_x, ov_y;
  assign ov_x = (rx < u_q + sw_q) && (u_q < rx + rw) && (rw != '0) && (sw_q != '0);
  assign ov_y = (ry < v_q + sh_q) && (v_q < ry + rh) && (rh != '0) && (sh_q != '0);

  logic [SW-1:0] jump_u, u_inc, r_end;
  assign u_inc  = u_q + SW'(1);
  assign r_end  = rx + rw;
  assign jump_u = (r_end > u_inc) ? r_end : u_inc;

  // new atlas size and per-axis border
  logic [ItemW-1:0] max_w, max_h;
  logic [BASEW-1:0] nw_raw, nh_raw;
  logic [DW-1:0]    nw, nh;
  logic [SW-1:0]    two_b, need_w, need_h;
  logic [PadW-1:0]  ub_new, vb_new;

  always_comb begin
    max_w  = (item_w_q > def_w_q) ? item_w_q : def_w_q;
    max_h  = (item_h_q > def_h_q) ? item_h_q : def_h_q;
    nw_raw = BASEW'(max_w);
    nh_raw = BASEW'(max_h);
    if (nw_raw == '0) nw_raw = BASEW'(1);
    if (nh_raw == '0) nh_raw = BASEW'(1);
    if (nw_raw > BASEW'(MAX_DIM)) nw_raw = BASEW'(MAX_DIM);
    if (nh_raw > BASEW'(MAX_DIM)) nh_raw = BASEW'(MAX_DIM);
    nw     = DW'(nw_raw);
    nh     = DW'(nh_raw);
    two_b  = SW'({border_q, 1'b0});
    need_w = SW'(item_w_q) + two_b;
    need_h = SW'(item_h_q) + two_b;
    ub_new = (SW'(nw) < need_w) ? '0 : border_q;
    vb_new = (SW'(nh) < need_h) ? '0 : border_q;
  end

  always_comb begin
    stat_o.atlases_done = (cur_a_q == open_q);
    stat_o.atlas_full   = (used_cur >= UCW'(MAX_REGIONS));
    stat_o.can_open     = (open_q < ACW'(MAX_ATLASES)) &&
                          (BASEW'(item_w_q) <= BASEW'(MAX_DIM)) &&
                          (BASEW'(item_h_q) <= BASEW'(MAX_DIM));
    stat_o.row_ok       = (v_q < ah) && (v_q + sh_q <= ah);
    stat_o.col_ok       = (u_q < aw) && (u_q + sw_q <= aw);
    stat_o.regions_done = (i_q == used_cur);
    stat_o.overlap      = ov_x && ov_y;
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= '0;
      cur_a_q <= '0;
      used_q  <= '{default: '0};
    end else begin
      if (cmd_i.first_atlas) cur_a_q <= '0;
      if (cmd_i.next_atlas)  cur_a_q <= cur_a_q + ACW'(1);
      if (cmd_i.open_new) begin
        cur_a_q       <= open_q;
        open_q        <= open_q + ACW'(1);
        used_q[o_idx] <= '0;
      end
      if (cmd_i.place) used_q[a_idx] <= used_cur + UCW'(1);
    end
  end

  // scan registers, atlas table and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_w_q <= item_width_i;
      item_h_q <= item_height_i;
    end
    if (cmd_i.atlas_init) begin
      ub_q <= border_q;
      vb_q <= border_q;
      sw_q <= need_w;
      sh_q <= need_h;
      v_q  <= '0;
    end
    if (cmd_i.open_new) begin
      dim_w_q[o_idx] <= nw;
      dim_h_q[o_idx] <= nh;
      ub_q <= ub_new;
      vb_q <= vb_new;
      sw_q <= SW'(item_w_q) + SW'({ub_new, 1'b0});
      sh_q <= SW'(item_h_q) + SW'({vb_new, 1'b0});
      v_q  <= '0;
    end
    if (cmd_i.row_init)    u_q <= '0;
    if (cmd_i.next_row)    v_q <= v_q + SW'(1);
    if (cmd_i.col_init)    i_q <= '0;
    if (cmd_i.next_region) i_q <= i_q + UCW'(1);
    if (cmd_i.next_col)    u_q <= jump_u;
    if (cmd_i.place) begin
      status_o      <= 1'b0;
      atlas_index_o <= OutIdxW'(cur_a_q);
      pos_x_o       <= OutCoordW'(u_q + SW'(ub_q));
      pos_y_o       <= OutCoordW'(v_q + SW'(vb_q));
      atlas_w_o     <= OutCoordW'(aw);
      atlas_h_o     <= OutCoordW'(ah);
    end
    if (cmd_i.set_fail) begin
      status_o      <= 1'b1;
      atlas_index_o <= '0;
      pos_x_o       <= '0;
      pos_y_o       <= '0;
      atlas_w_o     <= '0;
      atlas_h_o     <= '0;
    end
  end

  // region memory, one port; the write lands at the slot after the last region
  always_ff @(posedge clk_i) begin
    if (cmd_i.place) begin
      mem_q[addr] <= {RW'(sh_q + SW'(spacing_q)), RW'(sw_q + SW'(spacing_q)),
                      DW'(v_q), DW'(u_q)};
    end
    rd_q <= mem_q[addr];
  end

endmodule

@@ hdl/first_fit_atlas_rect_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_atlas_rect_allocator
// first-fit placement of rectangles into a growing set of texture atlases
// ----------------------------------------------------------------------------
// usage: each slave transfer carries one item size; the block answers with
// exactly one master transfer giving the atlas index, the position inside the
// border and the atlas size, or the no-room flag in tuser.
// open atlases are tried oldest first, rows top to bottom, columns left to
// right; each candidate slot is compared against the atlas's stored regions
// one at a time (memory read, then compare); a new atlas starts empty.
// one item is in work at a time: s_axis_tready is high only when idle, so
// a new item is taken only once the last result has been taken; a result
// holds on the master side until it is taken and a stalled receiver stalls
// the whole block. reset clears the atlas count, per-atlas region counts
// and configuration (1024 x 1024 default atlas, zero border and spacing);
// there is no clearing pass. configuration writes are to be made while
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_atlas_rect_allocator import ffara_pkg::*; #(
  parameter int unsigned MAX_ATLASES = 8,
  parameter int unsigned MAX_REGIONS = 64,
  parameter int unsigned MAX_DIM     = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // item_width[12:0], item_height[25:13], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // atlas_index[2:0], pos_x[15:3], pos_y[28:16], atlas_w[41:29], atlas_h[54:42]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // status: 0 placed, 1 no room
  output logic                m_axis_tuser_o
);

  cmd_t  cmd;
  stat_t stat;

  logic [OutIdxW-1:0]   atlas_index;
  logic [OutCoordW-1:0] pos_x, pos_y, atlas_w, atlas_h;

  ffara_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffara_dp #(
    .MAX_ATLASES (MAX_ATLASES),
    .MAX_REGIONS (MAX_REGIONS),
    .MAX_DIM     (MAX_DIM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .item_width_i  (s_axis_tdata_i[ItemW-1:0]),
    .item_height_i (s_axis_tdata_i[2*ItemW-1:ItemW]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (m_axis_tuser_o),
    .atlas_index_o (atlas_index),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .atlas_w_o     (atlas_w),
    .atlas_h_o     (atlas_h)
  );

  assign m_axis_tdata_o = {1'b0, atlas_h, atlas_w, pos_y, pos_x, atlas_index};

  `ASSERT_PROP(a_no_same_cycle_result, clk_i, rst_ni,
    (s_axis_tvalid_i && s_axis_tready_o) |=> !m_axis_tvalid_o)
  `ASSERT_NEVER(a_one_item_in_work, clk_i, rst_ni,
    s_axis_tready_o && m_axis_tvalid_o)
  `ASSERT_PROP(a_place_after_all_regions, clk_i, rst_ni,
    cmd.place |-> (stat.regions_done && !stat.atlases_done))

endmodule

@@ dv/first_fit_atlas_rect_allocator_checker.sv @@
// ----------------------------------------------------------------------------
// first_fit_atlas_rect_allocator_checker
// watches the config port and both stream channels, keeps its own copy of
// the atlas and region state, predicts each placement and compares results
// ----------------------------------------------------------------------------
module first_fit_atlas_rect_allocator_checker import ffara_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [OutDataW-1:0] m_axis_tdata_i,
  input  logic                m_axis_tuser_i,
  output int                  fail_count_o,
  output int                  result_count_o,
  output int                  pending_o,
  output int                  placed_count_o,
  output int                  no_room_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumAtlas = 8;
  localparam int NumRegion = 64;
  localparam int DimMax = 4096;

  typedef struct {
    int x, y, w, h;
  } box_t;

  typedef struct packed {
    logic                 no_room;
    logic [OutIdxW-1:0]   atlas;
    logic [OutCoordW-1:0] px, py, aw, ah;
  } placement_t;

  int def_w, def_h, border, gap;
  int n_open;
  int dim_w [NumAtlas];
  int dim_h [NumAtlas];
  int n_regions [NumAtlas];
  box_t regions [NumAtlas][NumRegion];
  placement_t placements_q [$];

  function automatic int first_hit(int a, int sx, int sy, int sw, int sh);
    int l, r, t, b;
    for (int i = 0; i < n_regions[a]; i++) begin
      box_t q;
      q = regions[a][i];
      l = (q.x > sx) ? q.x : sx;
      r = ((q.x + q.w) < (sx + sw)) ? (q.x + q.w) : (sx + sw);
      t = (q.y > sy) ? q.y : sy;
      b = ((q.y + q.h) < (sy + sh)) ? (q.y + q.h) : (sy + sh);
      if (r - l > 0 && b - t > 0) return i;
    end
    return -1;
  endfunction

  function automatic bit fit_in_atlas(int a, int w, int h, int ub, int vb,
                                      output int px, output int py);
    int sw, sh, u, hit, edge_x;
    px = 0;
    py = 0;
    if (n_regions[a] >= NumRegion) return 0;
    sw = w + 2 * ub;
    sh = h + 2 * vb;
    for (int v = 0; v < dim_h[a]; v++) begin
      if (v + sh > dim_h[a]) break;
      u = 0;
      while (u < dim_w[a]) begin
        if (u + sw > dim_w[a]) break;
        hit = first_hit(a, u, v, sw, sh);
        if (hit >= 0) begin
          edge_x = regions[a][hit].x + regions[a][hit].w - 1;
          if (edge_x > u) u = edge_x;
        end else begin
          regions[a][n_regions[a]] = '{x: u, y: v, w: sw + gap, h: sh + gap};
          n_regions[a]++;
          px = u + ub;
          py = v + vb;
          return 1;
        end
        u++;
      end
    end
    return 0;
  endfunction

  function automatic placement_t place_item(int w, int h);
    placement_t res;
    int a, px, py, nw, nh, ub, vb;
    bit ok;
    ok = 0;
    for (a = 0; a < n_open; a++) begin
      if (fit_in_atlas(a, w, h, border, border, px, py)) break;
    end
    if (a < n_open) begin
      ok = 1;
    end else if (n_open < NumAtlas && w <= DimMax && h <= DimMax) begin
      nw = (w > def_w) ? w : def_w;
      nh = (h > def_h) ? h : def_h;
      if (nw < 1) nw = 1;
      if (nh < 1) nh = 1;
      if (nw > DimMax) nw = DimMax;
      if (nh > DimMax) nh = DimMax;
      ub = (nw < w + 2 * border) ? 0 : border;
      vb = (nh < h + 2 * border) ? 0 : border;
      a = n_open;
      dim_w[a] = nw;
      dim_h[a] = nh;
      n_regions[a] = 0;
      n_open++;
      ok = fit_in_atlas(a, w, h, ub, vb, px, py);
    end
    res = '0;
    if (ok) begin
      res.atlas = a[OutIdxW-1:0];
      res.px = px[OutCoordW-1:0];
      res.py = py[OutCoordW-1:0];
      res.aw = dim_w[a][OutCoordW-1:0];
      res.ah = dim_h[a][OutCoordW-1:0];
    end else begin
      res.no_room = 1'b1;
    end
    return res;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  initial begin
    fail_count_o = 0;
    result_count_o = 0;
    placed_count_o = 0;
    no_room_count_o = 0;
    def_w = 1024;
    def_h = 1024;
    border = 0;
    gap = 0;
    n_open = 0;
    for (int i = 0; i < NumAtlas; i++) n_regions[i] = 0;
  end

  assign pending_o = placements_q.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_DEF_W:   def_w = cfg_data_i;
          CFG_DEF_H:   def_h = cfg_data_i;
          CFG_BORDER:  border = cfg_data_i[PadW-1:0];
          CFG_SPACING: gap = cfg_data_i[PadW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        placements_q = {placements_q, place_item(s_axis_tdata_i[ItemW-1:0],
                                                 s_axis_tdata_i[2*ItemW-1:ItemW])};
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        placement_t got, want;
        result_count_o++;
        got.no_room = m_axis_tuser_i;
        got.atlas = m_axis_tdata_i[2:0];
        got.px = m_axis_tdata_i[15:3];
        got.py = m_axis_tdata_i[28:16];
        got.aw = m_axis_tdata_i[41:29];
        got.ah = m_axis_tdata_i[54:42];
        if (placements_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result transfer with nothing expected, actual %h", $realtime, got);
        end else begin
          want = placements_q.pop_front();
          if (want.no_room) no_room_count_o++;
          else placed_count_o++;
          check_field("status", want.no_room, got.no_room);
          check_field("atlas_index", want.atlas, got.atlas);
          check_field("pos_x", want.px, got.px);
          check_field("pos_y", want.py, got.py);
          check_field("atlas_w", want.aw, got.aw);
          check_field("atlas_h", want.ah, got.ah);
        end
      end
    end
  end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the first-fit atlas rectangle allocator: directed
// extremes (empty, oversized, full-width items, dropped borders), then
// random phases of small items under varied atlas, border and spacing settings
// ----------------------------------------------------------------------------
module testbench import ffara_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  int fail_count, result_count, pending, placed_count, no_room_count;
  int items_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;

  always #6 clk_i = ~clk_i;

  first_fit_atlas_rect_allocator dut (.*);

  first_fit_atlas_rect_allocator_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .fail_count_o(fail_count),
    .result_count_o(result_count), .pending_o(pending),
    .placed_count_o(placed_count), .no_room_count_o(no_room_count)
  );

  // receiver stall pattern, mode changes every so often
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= ~m_axis_tready_i;
    endcase
  end

  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CfgW-1:0];
    @(posedge clk_i);
  endtask

  task automatic set_regs(int dw, int dh, int bs, int sp);
    write_reg(CFG_DEF_W, dw);
    write_reg(CFG_DEF_H, dh);
    write_reg(CFG_BORDER, bs);
    write_reg(CFG_SPACING, sp);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(int w, int h);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {6'd0, h[ItemW-1:0], w[ItemW-1:0]};
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  // hold off until every transfer sent has its result back
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (result_count != items_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    int w, h, pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
    end else if (pick < 96) begin
      w = $urandom_range(0, 16);
      h = $urandom_range(0, 16);
    end else if (pick < 98) begin
      w = $urandom_range(0, 8191);
      h = $urandom_range(1, 4);
    end else begin
      w = $urandom_range(1, 4);
      h = $urandom_range(0, 8191);
    end
    send_item(w, h);
  endtask

  initial begin
    #300_000_000;
    $display("timeout with %0d results still outstanding", items_sent - result_count);
    $display("** first_fit_atlas_rect_allocator: FAILED **");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest atlases: empty item, exact fit, fit failure, oversized item
    set_regs(1, 1, 0, 0);
    send_item(0, 0);
    send_item(1, 1);
    send_item(1, 1);
    send_item(8191, 5);
    send_item(5, 8191);
    send_item(4097, 1);
    drain();

    // full-width atlas with the widest border, border dropped on both axes
    set_regs(4096, 1, 255, 255);
    send_item(4096, 1);
    send_item(2, 0);
    drain();

    // small atlases with border and large spacing
    set_regs(48, 48, 2, 255);
    send_item(3, 3);
    send_item(3, 3);
    send_item(40, 7);
    send_item(44, 44);
    send_item(48, 48);
    send_item(1, 2);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      set_regs($urandom_range(8, 20), $urandom_range(8, 20),
               $urandom_range(0, 3), $urandom_range(0, 3));
      repeat (25) send_random_item();
      drain();
    end

    // largest item last, so no later search has to walk a huge atlas
    set_regs(4096, 4096, 0, 0);
    send_item(4096, 4096);
    drain();

    $display("sent %0d items over several register settings", items_sent);
    $display("%0d placed, %0d refused for lack of room", placed_count, no_room_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** first_fit_atlas_rect_allocator: PASSED **");
    end else begin
      $display("** first_fit_atlas_rect_allocator: FAILED **");
    end
    $finish;
  end

endmodule
